FILE: sv/pls_pkg.sv
// pls_pkg: shared types and codes for the positional list store
// no dependencies; used by plc_cell and positional_list_store
`default_nettype none

package pls_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int POS_W          = 5;
    localparam int CNT_W          = 5;
    localparam int WORD_W         = 32;
    localparam int WIDE_W         = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } t_out;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/plc_cell.sv
// plc_cell: one storage cell of the list chain, holds one word
// shifts from its lower or upper neighbor on insert or remove; uses pls_pkg
`default_nettype none

module plc_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire pls_pkg::t_cell_ctl    i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_lower,
    input  wire logic [DATA_WIDTH-1:0] i_upper,
    input  wire logic [DATA_WIDTH-1:0] i_acc,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic      [DATA_WIDTH-1:0] o_acc
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  hit;
    logic                  above;

    assign hit   = (int'(i_ctl.pos) == IDX);
    assign above = (IDX > int'(i_ctl.pos));

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && above) begin
            n_data = i_lower;
        end else if (i_ctl.ins && hit) begin
            n_data = i_word;
        end else if (i_ctl.rem && (above || hit)) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_acc  = hit ? (i_acc | r_data) : i_acc;

endmodule

`default_nettype wire

FILE: sv/positional_list_store.sv
// positional_list_store: ordered list of up to DEPTH words held in a chain of cells
// depends on pls_pkg and plc_cell
//
// One command per cycle: a transaction accepted on the input side updates every cell
// at once (each cell compares its index with the position and shifts, loads or holds)
// and its result is registered; the next command is accepted while a result waits, as
// long as the output register is free or being taken. Insert moves words at and above
// the position up; remove moves words above it down; read and remove return the word
// picked off the cell chain. Out of range reads or removes, inserts past the end and
// inserts into a full list report an error and leave the list unchanged. Clear empties
// the list. No clearing pass.
`default_nettype none

module positional_list_store #(
    parameter int DEPTH      = pls_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pls_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pls_pkg::t_out      o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    pls_pkg::t_out          r_out;
    pls_pkg::t_out          n_out;

    logic                   accept;
    logic [PW-1:0]          pos_x;
    logic [PW-1:0]          cnt_x;
    logic                   full;
    logic                   err;
    logic                   ins_ok;
    logic                   rem_ok;
    pls_pkg::t_cell_ctl     ctl;
    logic [pls_pkg::WIDE_W-1:0] wide_in;
    logic [pls_pkg::WIDE_W-1:0] wide_rd;
    logic [DATA_WIDTH-1:0]  word;

    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]  acc [DEPTH+1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_x = PW'(i_in_data.position);
    assign cnt_x = PW'(r_count);
    assign full  = (int'(r_count) == DEPTH);

    always_comb begin
        unique case (i_in_data.cmd)
            pls_pkg::CMD_INSERT: err = full || (pos_x > cnt_x);
            pls_pkg::CMD_READ:   err = (pos_x >= cnt_x);
            pls_pkg::CMD_REMOVE: err = (pos_x >= cnt_x);
            default:             err = 1'b0;
        endcase
    end

    assign ins_ok = accept && !err && (i_in_data.cmd == pls_pkg::CMD_INSERT);
    assign rem_ok = accept && !err && (i_in_data.cmd == pls_pkg::CMD_REMOVE);

    assign ctl.ins = ins_ok;
    assign ctl.rem = rem_ok;
    assign ctl.pos = i_in_data.position;

    assign wide_in = pls_pkg::WIDE_W'(i_in_data.value);
    assign word    = wide_in[DATA_WIDTH-1:0];

    assign acc[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;
        if (g == 0) begin : g_lo0
            assign lower = '0;
        end else begin : g_lo
            assign lower = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi0
            assign upper = '0;
        end else begin : g_hi
            assign upper = cell_data[g+1];
        end
        plc_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_word  (word),
            .i_lower (lower),
            .i_upper (upper),
            .i_acc   (acc[g]),
            .o_data  (cell_data[g]),
            .o_acc   (acc[g+1])
        );
    end

    assign wide_rd = pls_pkg::WIDE_W'(acc[DEPTH]);

    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (rem_ok) begin
            n_count = r_count - CW'(1);
        end else if (accept && (i_in_data.cmd == pls_pkg::CMD_CLEAR)) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_out.status     = err;
        n_out.read_value = '0;
        if (!err && ((i_in_data.cmd == pls_pkg::CMD_READ) ||
                     (i_in_data.cmd == pls_pkg::CMD_REMOVE))) begin
            n_out.read_value = wide_rd[pls_pkg::WORD_W-1:0];
        end
        n_out.count    = pls_pkg::CNT_W'(n_count);
        n_out.is_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("list count above depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_data.cmd == pls_pkg::CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty list");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow count");

    a_full_insert_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_in_data.cmd == pls_pkg::CMD_INSERT))
            |=> (o_out_valid && o_out_data.status && $stable(r_count)))
        else $error("insert into full list not flagged");
`endif

endmodule

`default_nettype wire

FILE: test/list_store_checker.sv
`timescale 1ns / 100ps
// list_store_checker: watches both channels of positional_list_store, keeps its own
// copy of the list and compares every result transaction field by field; uses pls_pkg

module list_store_checker #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  wire pls_pkg::t_in   i_in_data,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  wire pls_pkg::t_out  i_out_data,
    output int                  o_pending,
    output int                  o_mismatches,
    output int                  o_checked
);
    import pls_pkg::*;

    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_len;
    t_out              expected_results [$];
    int                n_mismatch;
    int                n_checked;

    assign o_mismatches = n_mismatch;
    assign o_checked    = n_checked;

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] seen,
                                   input logic [WORD_W-1:0] wanted);
        $display("%0t: mismatch on %0s: got %0h, expected %0h", $realtime, field, seen, wanted);
        n_mismatch++;
    endtask

    task automatic apply_list_command(input t_in c, output t_out r);
        int p;
        p = int'(c.position);
        r = '0;
        case (c.cmd)
            CMD_INSERT: begin
                if (list_len >= DEPTH || p > list_len) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
                    list_words[p] = c.value;
                    list_len++;
                end
            end
            CMD_READ: begin
                if (p >= list_len) r.status = 1'b1;
                else r.read_value = list_words[p];
            end
            CMD_REMOVE: begin
                if (p >= list_len) begin
                    r.status = 1'b1;
                end else begin
                    r.read_value = list_words[p];
                    for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        r.count    = CNT_W'(list_len);
        r.is_empty = (list_len == 0);
    endtask

    initial begin
        n_mismatch = 0;
        n_checked  = 0;
        list_len   = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        t_out seen;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            // results leave before the new command's expectation is queued
            if (i_out_valid && i_out_ready) begin
                seen = i_out_data;
                n_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", seen.read_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch("status", WORD_W'(seen.status),
                                        WORD_W'(want.status));
                    if (seen.read_value !== want.read_value)
                        report_mismatch("read_value", seen.read_value, want.read_value);
                    if (seen.count !== want.count)
                        report_mismatch("count", WORD_W'(seen.count), WORD_W'(want.count));
                    if (seen.is_empty !== want.is_empty)
                        report_mismatch("is_empty", WORD_W'(seen.is_empty),
                                        WORD_W'(want.is_empty));
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_list_command(i_in_data, want);
                expected_results.push_back(want);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench: directed and random command streams for positional_list_store with random
// stalls on both channels; checking is done by list_store_checker, needs pls_pkg

module testbench;
    import pls_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1120;
    localparam int CALM_ITEMS   = 150;
    localparam int STALL_LIMIT  = 2000;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int pending;
    int mismatches;
    int checked;

    bit calm;
    int fill;
    int idle_cycles;
    int sent_per_cmd [4];
    int full_hits;
    int empty_hits;

    positional_list_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    list_store_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, none in the calm tail
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic send_command(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word);
        int   gap;
        t_in  item;
        item.cmd      = op;
        item.position = pos;
        item.value    = word;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        sent_per_cmd[op]++;
        if (fill == DEPTH) full_hits++;
        if (fill == 0) empty_hits++;
        case (op)
            CMD_INSERT: if (fill < DEPTH && int'(pos) <= fill) fill++;
            CMD_READ:   ;
            CMD_REMOVE: if (int'(pos) < fill) fill--;
            default:    fill = 0;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int               pick;
        bit               grow;
        logic [1:0]       op;
        logic [POS_W-1:0] pos;

        calm = 1'b0;
        fill = 0;
        grow = 1'b0;
        full_hits = 0;
        empty_hits = 0;
        idle_cycles = 0;
        foreach (sent_per_cmd[k]) sent_per_cmd[k] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list errors, insert past the end, then in and out of range reads and removes
        send_command(CMD_READ, 5'd0, 32'h0);
        send_command(CMD_REMOVE, 5'd0, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 5'd1, 32'h1234_5678);
        send_command(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 5'd0, 32'h0000_0000);
        send_command(CMD_INSERT, 5'd2, 32'hA5A5_A5A5);
        send_command(CMD_INSERT, 5'd1, 32'h5A5A_5A5A);
        send_command(CMD_READ, 5'd3, 32'h0);
        send_command(CMD_READ, 5'd4, 32'h0);
        send_command(CMD_READ, 5'd31, 32'h0);
        send_command(CMD_REMOVE, 5'd1, 32'h0);
        send_command(CMD_REMOVE, 5'd2, 32'h0);
        send_command(CMD_REMOVE, 5'd31, 32'h0);
        // fill to the top, insert into a full list, then read, remove and clear
        while (fill < DEPTH) send_command(CMD_INSERT, POS_W'(fill), $urandom());
        send_command(CMD_INSERT, 5'd0, 32'hDEAD_BEEF);
        send_command(CMD_READ, 5'd15, 32'h0);
        send_command(CMD_REMOVE, 5'd0, 32'h0);
        send_command(CMD_CLEAR, 5'd31, 32'hFFFF_FFFF);
        send_command(CMD_CLEAR, 5'd0, 32'h0);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (n % 64 == 0) grow = !grow;
            if (n == RANDOM_ITEMS / 2) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 2) op = CMD_CLEAR;
            else if (pick < (grow ? 55 : 25)) op = CMD_INSERT;
            else if (pick < (grow ? 80 : 55)) op = CMD_READ;
            else op = CMD_REMOVE;
            if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
            else if (op == CMD_INSERT) pos = POS_W'($urandom_range(0, fill));
            else if (fill == 0) pos = '0;
            else pos = POS_W'($urandom_range(0, fill - 1));
            send_command(op, pos, pick_word());
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("covered %0d inserts, %0d reads, %0d removes, %0d clears; %0d results checked",
                 sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_READ], sent_per_cmd[CMD_REMOVE],
                 sent_per_cmd[CMD_CLEAR], checked);
        $display("commands on a full list: %0d, on an empty list: %0d", full_hits, empty_hits);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
